// File: src/pcsc_pkg.sv
// ----------------------------------------------------------------------------
// pcsc_pkg
// Shared constants, state encoding and control structs of the PWM channel
// setting calculator.
// ----------------------------------------------------------------------------
package pcsc_pkg;

	localparam int CHANNELS = 4;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int FREQ_W   = 20;
	localparam int PERIOD_W = 20;
	localparam int DUTY_W   = 19;
	localparam int LEVEL_W  = 7;
	localparam int INTEN_W  = 8;
	localparam int CHSEL_W  = 3;
	localparam int DIVR_W   = 7;

	localparam int DIV_STEPS = PERIOD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [PERIOD_W-1:0] US_PER_S   = PERIOD_W'(1000000);
	localparam logic [INTEN_W-1:0]  MAX_LEVEL  = INTEN_W'(100);
	localparam logic [INTEN_W-1:0]  HALF_LEVEL = INTEN_W'(50);
	localparam logic [INTEN_W-1:0]  DIV_HIGH   = INTEN_W'(100);

	localparam logic [FREQ_W-1:0] MIN_FREQ_RST = FREQ_W'(100);
	localparam logic [FREQ_W-1:0] MAX_FREQ_RST = FREQ_W'(10000);

	localparam logic OP_SET    = 1'b0;
	localparam logic OP_STATUS = 1'b1;

	localparam logic REG_MIN_FREQ = 1'b0;
	localparam logic REG_MAX_FREQ = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV_PERIOD,
		ST_LOAD_DUTY,
		ST_DIV_DUTY,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic start_period;
		logic start_duty;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic needs_div;
		logic div_last;
		logic out_busy;
	} sts_t;

endpackage

// File: src/pcsc_if.sv
// ----------------------------------------------------------------------------
// pcsc interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcsc_req_if;
	logic                              valid;
	logic                              ready;
	logic                              op;
	logic [pcsc_pkg::CHSEL_W-1:0]      channel;
	logic [pcsc_pkg::FREQ_W-1:0]       frequency;
	logic [pcsc_pkg::INTEN_W-1:0]      intensity;

	modport source (output valid, op, channel, frequency, intensity, input ready);
	modport sink   (input valid, op, channel, frequency, intensity, output ready);
endinterface

interface pcsc_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              status;
	logic                              stop_first;
	logic [pcsc_pkg::PERIOD_W-1:0]     old_period_us;
	logic [pcsc_pkg::PERIOD_W-1:0]     period_us;
	logic [pcsc_pkg::DUTY_W-1:0]       duty_us;
	logic                              enabled;
	logic [pcsc_pkg::LEVEL_W-1:0]      level_now;

	modport source (output valid, status, stop_first, old_period_us, period_us, duty_us,
		enabled, level_now, input ready);
	modport sink   (input valid, status, stop_first, old_period_us, period_us, duty_us,
		enabled, level_now, output ready);
endinterface

interface pcsc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic                              index;
	logic [pcsc_pkg::FREQ_W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: src/pcsc_ctrl.sv
// ----------------------------------------------------------------------------
// pcsc_ctrl
// Sequencer: classifies the request, runs the period and duty divisions on
// the shared divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module pcsc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  pcsc_pkg::sts_t  sts,
	output pcsc_pkg::cmd_t  cmd
);

	pcsc_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pcsc_pkg::ST_IDLE: begin
				if (req_valid) state_nx = pcsc_pkg::ST_EVAL;
			end
			pcsc_pkg::ST_EVAL: begin
				state_nx = sts.needs_div ? pcsc_pkg::ST_DIV_PERIOD : pcsc_pkg::ST_EMIT;
			end
			pcsc_pkg::ST_DIV_PERIOD: begin
				if (sts.div_last) state_nx = pcsc_pkg::ST_LOAD_DUTY;
			end
			pcsc_pkg::ST_LOAD_DUTY: begin
				state_nx = pcsc_pkg::ST_DIV_DUTY;
			end
			pcsc_pkg::ST_DIV_DUTY: begin
				if (sts.div_last) state_nx = pcsc_pkg::ST_EMIT;
			end
			pcsc_pkg::ST_EMIT: begin
				if (!sts.out_busy) state_nx = pcsc_pkg::ST_IDLE;
			end
			default: begin
				state_nx = pcsc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			pcsc_pkg::ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			pcsc_pkg::ST_EVAL: begin
				cmd.start_period = sts.needs_div;
			end
			pcsc_pkg::ST_DIV_PERIOD: begin
				cmd.step = 1'b1;
			end
			pcsc_pkg::ST_LOAD_DUTY: begin
				cmd.start_duty = 1'b1;
			end
			pcsc_pkg::ST_DIV_DUTY: begin
				cmd.step = 1'b1;
			end
			pcsc_pkg::ST_EMIT: begin
				cmd.emit = !sts.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: src/pcsc_dp.sv
// ----------------------------------------------------------------------------
// pcsc_dp
// Datapath: request and limit registers, per-channel state, a restoring
// divider shared by both divisions, and the response register.
// ----------------------------------------------------------------------------
module pcsc_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           op,
	input  logic [pcsc_pkg::CHSEL_W-1:0]   channel,
	input  logic [pcsc_pkg::FREQ_W-1:0]    frequency,
	input  logic [pcsc_pkg::INTEN_W-1:0]   intensity,
	pcsc_cfg_if.sink                       cfg,
	pcsc_rsp_if.source                     rsp,
	input  pcsc_pkg::cmd_t                 cmd,
	output pcsc_pkg::sts_t                 sts
);

	// request registers
	logic                            op_q;
	logic [pcsc_pkg::CHSEL_W-1:0]    ch_q;
	logic [pcsc_pkg::FREQ_W-1:0]     freq_q;
	logic [pcsc_pkg::INTEN_W-1:0]    lvl_q;

	// limits
	logic [pcsc_pkg::FREQ_W-1:0]     min_freq_q;
	logic [pcsc_pkg::FREQ_W-1:0]     max_freq_q;

	// channel state
	logic                            on_q     [pcsc_pkg::CHANNELS];
	logic [pcsc_pkg::LEVEL_W-1:0]    level_q  [pcsc_pkg::CHANNELS];
	logic [pcsc_pkg::PERIOD_W-1:0]   last_q   [pcsc_pkg::CHANNELS];

	// divider
	logic [pcsc_pkg::PERIOD_W-1:0]   num_q;
	logic [pcsc_pkg::PERIOD_W-1:0]   rem_q;
	logic [pcsc_pkg::PERIOD_W-1:0]   den_q;
	logic [pcsc_pkg::CNT_W-1:0]      cnt_q;
	logic [pcsc_pkg::PERIOD_W-1:0]   period_q;
	logic [pcsc_pkg::PERIOD_W:0]     trial;
	logic                            qbit;

	// response register
	logic                            out_valid_q;
	logic                            status_q;
	logic                            stop_q;
	logic [pcsc_pkg::PERIOD_W-1:0]   old_q;
	logic [pcsc_pkg::PERIOD_W-1:0]   per_out_q;
	logic [pcsc_pkg::DUTY_W-1:0]     duty_out_q;
	logic                            en_out_q;
	logic [pcsc_pkg::LEVEL_W-1:0]    lvl_out_q;

	logic [pcsc_pkg::CH_W-1:0]       idx;
	logic                            bad_ch;
	logic                            is_status;
	logic                            is_disable;
	logic                            out_range;
	logic                            cur_on;
	logic [pcsc_pkg::LEVEL_W-1:0]    cur_level;
	logic [pcsc_pkg::PERIOD_W-1:0]   cur_last;
	logic [pcsc_pkg::INTEN_W-1:0]    divisor;

	assign idx        = ch_q[pcsc_pkg::CH_W-1:0];
	assign bad_ch     = 32'(ch_q) >= 32'(pcsc_pkg::CHANNELS);
	assign is_status  = (op_q == pcsc_pkg::OP_STATUS);
	assign is_disable = (freq_q == '0) || (lvl_q == '0);
	assign out_range  = (freq_q < min_freq_q) || (freq_q > max_freq_q)
		|| (lvl_q > pcsc_pkg::MAX_LEVEL);

	assign cur_on    = bad_ch ? 1'b0 : on_q[idx];
	assign cur_level = bad_ch ? '0 : level_q[idx];
	assign cur_last  = bad_ch ? '0 : last_q[idx];

	// floor(98*L/100) equals L - ceil(L/50) for L in 1..100, so the divisor
	// is 100 - L plus one or two; it never leaves 2..100
	assign divisor = pcsc_pkg::DIV_HIGH - lvl_q
		+ ((lvl_q > pcsc_pkg::HALF_LEVEL) ? pcsc_pkg::INTEN_W'(2) : pcsc_pkg::INTEN_W'(1));

	assign sts.needs_div = !bad_ch && !is_status && !is_disable && !out_range;
	assign sts.div_last  = (cnt_q == pcsc_pkg::CNT_W'(pcsc_pkg::DIV_STEPS - 1));
	assign sts.out_busy  = out_valid_q && !rsp.ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			ch_q   <= channel;
			freq_q <= frequency;
			lvl_q  <= intensity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_freq_q <= pcsc_pkg::MIN_FREQ_RST;
			max_freq_q <= pcsc_pkg::MAX_FREQ_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pcsc_pkg::REG_MIN_FREQ: min_freq_q <= cfg.data;
				pcsc_pkg::REG_MAX_FREQ: max_freq_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// one quotient bit per step, MSB first
	assign trial = {rem_q, num_q[pcsc_pkg::PERIOD_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.start_period) begin
			num_q <= pcsc_pkg::US_PER_S;
			rem_q <= '0;
			den_q <= freq_q;
			cnt_q <= '0;
		end else if (cmd.start_duty) begin
			period_q <= num_q;
			rem_q    <= '0;
			den_q    <= pcsc_pkg::PERIOD_W'(divisor);
			cnt_q    <= '0;
		end else if (cmd.step) begin
			rem_q <= qbit ? pcsc_pkg::PERIOD_W'(trial - {1'b0, den_q})
				: trial[pcsc_pkg::PERIOD_W-1:0];
			num_q <= {num_q[pcsc_pkg::PERIOD_W-2:0], qbit};
			cnt_q <= cnt_q + pcsc_pkg::CNT_W'(1);
		end
	end

	// update channel state on emit of a set request that is not rejected
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcsc_pkg::CHANNELS; i++) begin
				on_q[i]    <= 1'b0;
				level_q[i] <= '0;
				last_q[i]  <= '0;
			end
		end else if (cmd.emit && !bad_ch && !is_status) begin
			if (is_disable) begin
				on_q[idx]    <= 1'b0;
				level_q[idx] <= '0;
				last_q[idx]  <= '0;
			end else if (!out_range) begin
				on_q[idx]    <= 1'b1;
				level_q[idx] <= lvl_q[pcsc_pkg::LEVEL_W-1:0];
				last_q[idx]  <= period_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q   <= pcsc_pkg::STATUS_OK;
			stop_q     <= 1'b0;
			old_q      <= '0;
			per_out_q  <= '0;
			duty_out_q <= '0;
			en_out_q   <= 1'b0;
			lvl_out_q  <= '0;
			if (bad_ch) begin
				status_q <= pcsc_pkg::STATUS_ERR;
			end else if (is_status) begin
				en_out_q  <= cur_on;
				lvl_out_q <= cur_on ? cur_level : '0;
			end else if (is_disable) begin
				stop_q <= (cur_last != '0);
				old_q  <= cur_last;
			end else if (out_range) begin
				status_q  <= pcsc_pkg::STATUS_ERR;
				en_out_q  <= cur_on;
				lvl_out_q <= cur_on ? cur_level : '0;
			end else begin
				stop_q     <= (cur_last != '0);
				old_q      <= cur_last;
				per_out_q  <= period_q;
				duty_out_q <= num_q[pcsc_pkg::DUTY_W-1:0];
				en_out_q   <= 1'b1;
				lvl_out_q  <= lvl_q[pcsc_pkg::LEVEL_W-1:0];
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.stop_first    = stop_q;
	assign rsp.old_period_us = old_q;
	assign rsp.period_us     = per_out_q;
	assign rsp.duty_us       = duty_out_q;
	assign rsp.enabled       = en_out_q;
	assign rsp.level_now     = lvl_out_q;

endmodule

// File: src/pwm_channel_setting_calculator.sv
// ----------------------------------------------------------------------------
// pwm_channel_setting_calculator
// Flow: status, rejected and disable requests go from idle through evaluate
// to emit; an accepted set request runs the period and duty divisions (each
// 20 steps, one quotient bit per cycle) on one shared restoring divider
// between evaluate and emit. One request is in flight; the next is taken
// once the response is in the output register.
// Reset: all channels off with zero level and period, limits 100 and 10000 Hz.
// ----------------------------------------------------------------------------
module pwm_channel_setting_calculator (
	input  logic        clk,
	input  logic        arst_n,
	pcsc_req_if.sink    req,
	pcsc_rsp_if.source  rsp,
	pcsc_cfg_if.sink    cfg
);

	pcsc_pkg::cmd_t cmd;
	pcsc_pkg::sts_t sts;
	logic           req_ready;

	assign req.ready = req_ready;

	pcsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pcsc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (req.op),
		.channel   (req.channel),
		.frequency (req.frequency),
		.intensity (req.intensity),
		.cfg       (cfg),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

	// one request at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while another is in flight");

	// never overwrite a response that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(rsp.valid && !rsp.ready))
		else $error("response overwritten");

	// divider steps right after the period division is started
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_period |=> cmd.step)
		else $error("divider did not start");

endmodule
